@@ hdl/polyphase_fractional_resampler_macros.svh @@
// Assertion macros for the polyphase resampler RTL.
// Used by files that check internal invariants; expects clk and rst_n in scope.
`ifndef POLYPHASE_FRACTIONAL_RESAMPLER_MACROS_SVH
`define POLYPHASE_FRACTIONAL_RESAMPLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RSMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RSMP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define RSMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rsmp_pkg.sv @@
// Shared types and constants of the polyphase resampler.
// No dependencies; imported by the top, front and back modules.
`default_nettype none

package rsmp_pkg;

    localparam int unsigned MAX_BLOCK_DEF      = 64;
    localparam int unsigned TAPS_MINUS_ONE_DEF = 7;

    // input opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_BASE   = 2'd2;

    // request kinds between front and back
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_BASE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_IN_LEN  = 1'b0;
    localparam logic CFG_OUT_LEN = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [5:0]         phase_index;
        logic [2:0]         tap_index;
        logic signed [15:0] coeff_value;
        logic [5:0]         base_index;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_re;
        logic signed [15:0] out_im;
        logic               last_of_block;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  phase;
        logic [2:0]  tap;
        logic [31:0] data;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/polyphase_fractional_resampler.sv @@
// Polyphase rational resampler for complex 16-bit samples.
// Input side is a queue with push/full carrying in_data; results leave through
// a queue with empty/pop carrying out_data. A push writes a sample, a coefficient
// or a phase base index; table writes must precede the blocks that use them.
// Registers in_block_len (index 0) and out_block_len (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// A sample that completes a block starts out_block_len results. Each result
// goes through base lookup (S_BASE, S_BWAIT), one tap per cycle on the shared
// MAC (S_MAC), drain (S_DRAIN) and emit (S_EMIT), which holds while the result
// queue is full. After the last result the history copy (S_COPY) runs. Other
// items are taken in the idle state; the request queue holds two items.
// A stalled receiver fills the two-entry result queue, then the engine holds.
// Reset clears the sample history to zero, the fill count, and sets both
// lengths to 1; coefficient and base tables are undefined until written.
// Depends on rsmp_pkg, rsmp_fifo, rsmp_front and rsmp_back.
`default_nettype none

module polyphase_fractional_resampler #(
    parameter int unsigned MaxBlock     = rsmp_pkg::MAX_BLOCK_DEF,
    parameter int unsigned TapsMinusOne = rsmp_pkg::TAPS_MINUS_ONE_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire rsmp_pkg::in_item_t  in_data,
    output logic                     empty,
    input  wire logic                pop,
    output rsmp_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [6:0]          cfg_data
);
    import rsmp_pkg::*;

    localparam int unsigned Taps = TapsMinusOne + 1;

    logic [6:0] in_len_val_reg;
    logic [6:0] out_len_val_reg;
    logic       cmd_pop;
    logic       cmd_empty;
    cmd_t       cmd;
    logic       res_full;
    logic       res_push;
    out_item_t  res;
    logic [$bits(out_item_t)-1:0] res_vec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_val_reg  <= 7'd1;
            out_len_val_reg <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IN_LEN:  in_len_val_reg  <= cfg_data;
                CFG_OUT_LEN: out_len_val_reg <= cfg_data;
                default:     in_len_val_reg  <= in_len_val_reg;
            endcase
        end
    end

    rsmp_front #(
        .MaxBlock (MaxBlock),
        .Taps     (Taps)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    rsmp_back #(
        .MaxBlock (MaxBlock),
        .Taps     (Taps)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .in_len    (in_len_val_reg),
        .out_len   (out_len_val_reg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    rsmp_fifo #(
        .Width ($bits(out_item_t)),
        .Depth (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (res_vec)
    );

    assign out_data = out_item_t'(res_vec);

endmodule

`default_nettype wire

@@ hdl/rsmp_fifo.sv @@
// Small first-in first-out queue of generic width.
// Standalone; used between front and back and on the result side.
`default_nettype none

module rsmp_fifo #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [Width-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic [Width-1:0]      rdata
);

    localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] mem_reg [Depth];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                     (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg[PW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg[PW-1:0]] <= wdata;
    end

endmodule

`default_nettype wire

@@ hdl/rsmp_front.sv @@
// Front end: accepts input items, drops invalid ones, queues requests.
// Depends on rsmp_pkg and rsmp_fifo.
`default_nettype none

module rsmp_front #(
    parameter int unsigned MaxBlock = 64,
    parameter int unsigned Taps     = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rsmp_pkg::in_item_t in_data,
    input  wire logic              cmd_pop,
    output logic                   cmd_empty,
    output rsmp_pkg::cmd_t         cmd
);
    import rsmp_pkg::*;

    cmd_t cmd_in;
    logic keep;
    logic [$bits(cmd_t)-1:0] cmd_vec;

    always_comb
    begin
        cmd_in.kind  = CMD_SAMPLE;
        cmd_in.phase = in_data.phase_index;
        cmd_in.tap   = in_data.tap_index;
        cmd_in.data  = {in_data.sample_im, in_data.sample_re};
        keep         = 1'b0;
        case (in_data.opcode)
            OP_SAMPLE:
            begin
                keep = 1'b1;
            end
            OP_COEF:
            begin
                cmd_in.kind = CMD_COEF;
                cmd_in.data = {16'b0, in_data.coeff_value};
                keep = (32'(in_data.phase_index) < MaxBlock) &&
                       (32'(in_data.tap_index) < Taps);
            end
            OP_BASE:
            begin
                cmd_in.kind = CMD_BASE;
                cmd_in.data = {26'b0, in_data.base_index};
                keep = (32'(in_data.phase_index) < MaxBlock);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // drop unused opcodes and out-of-range writes at acceptance
    rsmp_fifo #(
        .Width ($bits(cmd_t)),
        .Depth (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .full  (full),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_vec)
    );

    assign cmd = cmd_t'(cmd_vec);

endmodule

`default_nettype wire

@@ hdl/rsmp_back.sv @@
// Back end: sample store, coefficient and base tables, and the MAC engine.
// Depends on rsmp_pkg and polyphase_fractional_resampler_macros.svh.
`default_nettype none

module rsmp_back #(
    parameter int unsigned MaxBlock = 64,
    parameter int unsigned Taps     = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    input  wire rsmp_pkg::cmd_t cmd,
    input  wire logic [6:0]     in_len,
    input  wire logic [6:0]     out_len,
    input  wire logic           res_full,
    output logic                res_push,
    output rsmp_pkg::out_item_t res
);
    import rsmp_pkg::*;

    localparam int unsigned ST_DEPTH = MaxBlock + Taps;
    localparam int unsigned ST_AW    = $clog2(ST_DEPTH);
    localparam int unsigned CF_DEPTH = MaxBlock * Taps;
    localparam int unsigned CF_AW    = $clog2(CF_DEPTH);
    localparam int unsigned BW       = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;
    localparam int unsigned LEN_W    = $clog2(MaxBlock + 1);
    localparam int unsigned TW       = $clog2(Taps);
    localparam int unsigned CW       = TW + 1;
    localparam int unsigned AW       = 33 + TW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_BWAIT = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_COPY  = 3'd6;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [6:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if (v == 7'd0)
                return LEN_W'(1);
            if (w > MaxBlock)
                return LEN_W'(MaxBlock);
            return LEN_W'(w);
        end
    endfunction

    // memories
    logic [31:0]         store_mem [ST_DEPTH];
    logic signed [15:0]  coef_mem  [CF_DEPTH];
    logic [5:0]          base_mem  [MaxBlock];
    logic [ST_DEPTH-1:0] st_vld_reg;

    logic [31:0]        st_rdata_reg;
    logic               st_rvld_reg;
    logic signed [15:0] cf_rdata_reg;
    logic [5:0]         bs_rdata_reg;

    logic             st_we;
    logic [ST_AW-1:0] st_waddr;
    logic [31:0]      st_wdata;
    logic [ST_AW-1:0] st_raddr;
    logic             cf_we;
    logic [CF_AW-1:0] cf_waddr;
    logic [CF_AW-1:0] cf_raddr;
    logic             bs_we;
    logic [BW-1:0]    bs_raddr;
    logic [31:0]      st_masked;

    // control
    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [BW-1:0]    j_reg, j_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [LEN_W-1:0] ilen_reg, ilen_next;
    logic [LEN_W-1:0] olen_reg, olen_next;
    logic [LEN_W-1:0] ilen_eff;
    logic [LEN_W-1:0] olen_eff;
    logic             issue;
    logic             acc_clr;
    logic             is_last;

    // datapath
    logic               v1_reg;
    logic               v2_reg;
    logic signed [31:0] prod_re_reg;
    logic signed [31:0] prod_im_reg;
    logic signed [AW-1:0] acc_re_reg;
    logic signed [AW-1:0] acc_im_reg;

    assign ilen_eff  = clamp_len(in_len);
    assign olen_eff  = clamp_len(out_len);
    assign st_masked = st_rvld_reg ? st_rdata_reg : 32'd0;
    assign is_last   = (LEN_W'(j_reg) + LEN_W'(1)) == olen_reg;
    assign cf_waddr  = CF_AW'(CF_AW'(cmd.phase) * CF_AW'(Taps)) + CF_AW'(cmd.tap);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        ilen_next  = ilen_reg;
        olen_next  = olen_reg;
        cmd_pop    = 1'b0;
        st_we      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_raddr   = '0;
        cf_we      = 1'b0;
        cf_raddr   = '0;
        bs_we      = 1'b0;
        bs_raddr   = '0;
        issue      = 1'b0;
        acc_clr    = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_SAMPLE:
                        begin
                            st_we    = 1'b1;
                            st_waddr = ST_AW'(Taps) + ST_AW'(fill_reg);
                            st_wdata = cmd.data;
                            if ((fill_reg + LEN_W'(1)) >= ilen_eff)
                            begin
                                fill_next  = '0;
                                ilen_next  = ilen_eff;
                                olen_next  = olen_eff;
                                j_next     = '0;
                                state_next = S_BASE;
                            end
                            else
                            begin
                                fill_next = fill_reg + LEN_W'(1);
                            end
                        end
                        CMD_COEF:
                        begin
                            cf_we = 1'b1;
                        end
                        CMD_BASE:
                        begin
                            bs_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BASE:
            begin
                bs_raddr   = j_reg;
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (32'(bs_rdata_reg) > MaxBlock - 1)
                    b_next = BW'(MaxBlock - 1);
                else
                    b_next = BW'(bs_rdata_reg);
                k_next     = '0;
                acc_clr    = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                issue    = 1'b1;
                st_raddr = ST_AW'(Taps) + ST_AW'(b_reg) - ST_AW'(k_reg);
                cf_raddr = CF_AW'(CF_AW'(j_reg) * CF_AW'(Taps)) + CF_AW'(k_reg);
                if (k_reg == CW'(Taps - 1))
                    state_next = S_DRAIN;
                else
                    k_next = k_reg + CW'(1);
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (is_last)
                    begin
                        k_next     = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        j_next     = j_reg + BW'(1);
                        state_next = S_BASE;
                    end
                end
            end
            S_COPY:
            begin
                // read block tail ahead of writing it to history
                if (k_reg < CW'(Taps))
                    st_raddr = ST_AW'(ilen_reg) + ST_AW'(k_reg);
                if (k_reg != '0)
                begin
                    st_we    = 1'b1;
                    st_waddr = ST_AW'(k_reg - CW'(1));
                    st_wdata = st_masked;
                end
                if (k_reg == CW'(Taps))
                    state_next = S_IDLE;
                else
                    k_next = k_reg + CW'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            b_reg      <= '0;
            ilen_reg   <= LEN_W'(1);
            olen_reg   <= LEN_W'(1);
            st_vld_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            b_reg     <= b_next;
            ilen_reg  <= ilen_next;
            olen_reg  <= olen_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (st_we)
                st_vld_reg[st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        st_rdata_reg <= store_mem[st_raddr];
        st_rvld_reg  <= st_vld_reg[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_we)
            coef_mem[cf_waddr] <= cmd.data[15:0];
        cf_rdata_reg <= coef_mem[cf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
            base_mem[BW'(cmd.phase)] <= cmd.data[5:0];
        bs_rdata_reg <= base_mem[bs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_re_reg <= $signed(st_masked[15:0]) * cf_rdata_reg;
            prod_im_reg <= $signed(st_masked[31:16]) * cf_rdata_reg;
        end
        if (acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + AW'(prod_re_reg);
            acc_im_reg <= acc_im_reg + AW'(prod_im_reg);
        end
    end

    function automatic logic signed [15:0] round_sat(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] s;
        logic signed [AW-16:0] q;
        begin
            s = a + AW'(16384);
            q = s[AW-1:15];
            if (q > (AW-15)'(32767))
                return 16'sd32767;
            if (q < -(AW-15)'(32768))
                return -16'sd32768;
            return q[15:0];
        end
    endfunction

    assign res.out_re        = round_sat(acc_re_reg);
    assign res.out_im        = round_sat(acc_im_reg);
    assign res.last_of_block = is_last;

`include "polyphase_fractional_resampler_macros.svh"

    `RSMP_ASSERT(a_fill_bound, 32'(fill_reg) < MaxBlock, "fill count reached block capacity")
    `RSMP_ASSERT(a_no_wr_in_mac, !(st_we && issue), "store written during MAC reads")
    `RSMP_ASSERT_NEXT(a_last_copies, res_push && is_last, state_reg == S_COPY, "no history copy")
    `RSMP_ASSERT_IMPL(a_pipe_order, v2_reg, $past(v1_reg), "product without read")
    `RSMP_ASSERT_IMPL(a_pop_idle, cmd_pop, state_reg == S_IDLE && !cmd_empty, "bad request pop")

endmodule

`default_nettype wire
